/* design/tazd_pkg.sv */
// Shared types and constants for the tilt averaging block.
// Holds the input and result item structs and the field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tazd_pkg;

  // Field widths.
  localparam int ANGLE_W = 16;
  localparam int MAG_W   = 16;
  localparam int OFFS_W  = 15;
  localparam int DB_W    = 10;

  // Reset value of the deadband register.
  localparam logic [DB_W-1:0] DB_RESET = 10'd10;

  // Largest mean magnitude, limited by the offset width.
  localparam logic [OFFS_W-1:0] OFFS_MAX = {OFFS_W{1'b1}};

  // Default number of samples per block.
  localparam int AVG_LEN_DEF = 8;

  // One input item.
  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_x;
    logic signed [ANGLE_W-1:0] angle_y;
    logic                      zero_req;
    logic                      clear_offset;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [MAG_W-1:0]          tilt_x_mag;
    logic                      tilt_x_neg;
    logic [MAG_W-1:0]          tilt_y_mag;
    logic                      tilt_y_neg;
    logic signed [ANGLE_W-1:0] tilt_x_value;
  } out_item_t;

endpackage

`default_nettype wire

/* design/tazd_accum.sv */
// Sample accumulator: sums X and Y angles over one block and counts samples.
// Flags the item after a full block as a trigger. Depends on tazd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tazd_accum
  import tazd_pkg::*;
#(
  parameter int AVG_LEN = AVG_LEN_DEF,
  localparam int SUM_W  = ANGLE_W + $clog2(AVG_LEN),
  localparam int CNT_W  = $clog2(AVG_LEN + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic signed [ANGLE_W-1:0] angle_x,
  input  wire logic signed [ANGLE_W-1:0] angle_y,
  output logic                           trigger,
  output logic signed [SUM_W-1:0]        sum_x,
  output logic signed [SUM_W-1:0]        sum_y
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(AVG_LEN);

  logic signed [SUM_W-1:0] sum_x_r, sum_x_nxt;
  logic signed [SUM_W-1:0] sum_y_r, sum_y_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] ext_x;
  logic signed [SUM_W-1:0] ext_y;

  // A full block makes the next item a trigger.
  assign trigger = (cnt_r == CNT_FULL);
  assign ext_x   = SUM_W'(angle_x);
  assign ext_y   = SUM_W'(angle_y);

  // Add a sample, or restart the block after a trigger.
  always_comb begin
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      if (trigger) begin
        sum_x_nxt = '0;
        sum_y_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        sum_x_nxt = sum_x_r + ext_x;
        sum_y_nxt = sum_y_r + ext_y;
        cnt_nxt   = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      cnt_r   <= '0;
    end else begin
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign sum_x = sum_x_r;
  assign sum_y = sum_y_r;

endmodule

`default_nettype wire

/* design/tazd_axis.sv */
// Per-axis result logic: rounded block mean, offset subtraction and deadband.
// Purely combinational; state lives in the top level. Depends on tazd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tazd_axis
  import tazd_pkg::*;
#(
  parameter int AVG_LEN = AVG_LEN_DEF,
  localparam int SUM_W  = ANGLE_W + $clog2(AVG_LEN)
) (
  input  wire logic signed [SUM_W-1:0]   sum,
  input  wire logic [OFFS_W-1:0]         offset,
  input  wire logic signed [ANGLE_W-1:0] prev,
  input  wire logic [DB_W-1:0]           deadband,
  output logic [OFFS_W-1:0]              mean_abs,
  output logic signed [ANGLE_W-1:0]      rel_held,
  output logic [MAG_W-1:0]               mag,
  output logic                           neg
);

  // Division by AVG_LEN as a multiply by a rounded-up reciprocal, which is
  // exact for every dividend below 2**NUM_W.
  localparam int NUM_W  = SUM_W + 1;
  localparam int SHIFT  = NUM_W + $clog2(AVG_LEN);
  localparam int RCP_W  = NUM_W + 1;
  localparam int PROD_W = NUM_W + RCP_W;
  localparam longint unsigned RCP_VAL =
    ((64'd1 << SHIFT) + longint'(AVG_LEN) - 64'd1) / longint'(AVG_LEN);
  localparam logic [RCP_W-1:0] RCP  = RCP_W'(RCP_VAL);
  localparam logic [NUM_W-1:0] HALF = NUM_W'(AVG_LEN / 2);
  localparam int DIFF_W = ANGLE_W + 1;

  logic                      sum_neg;
  logic [SUM_W-1:0]          sum_mag;
  logic [NUM_W-1:0]          num;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         quo_full;
  logic [NUM_W-1:0]          quo;
  logic                      mean_neg;
  logic signed [ANGLE_W-1:0] rel;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         diff_abs;
  logic                      hold;

  // Magnitude of the sum and rounded quotient, ties away from zero.
  assign sum_neg  = sum[SUM_W-1];
  assign sum_mag  = sum_neg ? SUM_W'(-sum) : SUM_W'(sum);
  assign num      = NUM_W'(sum_mag) + HALF;
  assign prod     = PROD_W'(num) * PROD_W'(RCP);
  assign quo_full = prod >> SHIFT;
  assign quo      = quo_full[NUM_W-1:0];
  assign mean_neg = sum_neg && (quo != '0);

  // Saturate to the offset width.
  assign mean_abs = (quo > NUM_W'(OFFS_MAX)) ? OFFS_MAX : quo[OFFS_W-1:0];

  // Relative value and its arrow.
  assign rel = $signed(ANGLE_W'(mean_abs)) - $signed(ANGLE_W'(offset));
  assign neg = (offset != '0) ? rel[ANGLE_W-1] : mean_neg;

  // Hold the previous value while the change stays under the threshold.
  assign diff     = DIFF_W'(rel) - DIFF_W'(prev);
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign hold     = diff_abs < DIFF_W'(deadband);
  assign rel_held = hold ? prev : rel;
  assign mag      = rel_held[ANGLE_W-1] ? MAG_W'(-rel_held) : MAG_W'(rel_held);

endmodule

`default_nettype wire

/* design/tilt_average_zero_deadband_top.sv */
// Tilt averaging top level: handshakes, offsets, held values, result register.
// Depends on tazd_pkg, tazd_accum and tazd_axis.
// Throughput: one item per cycle, but a trigger item stalls while a result waits.
// The result path, through the reciprocal multiply of the mean, is registered
// as the trigger is accepted. Samples are taken even while a result waits.
// Reset (synchronous, rst_n low) clears sums, count, offsets, held values,
// the zero request and the result valid flag, and sets the deadband to 10.
`timescale 1ns / 1ps
`default_nettype none

module tilt_average_zero_deadband_top
  import tazd_pkg::*;
#(
  parameter int AVG_LEN = AVG_LEN_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire in_item_t        in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output out_item_t            out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [DB_W-1:0] cfg_data
);

  localparam int SUM_W = ANGLE_W + $clog2(AVG_LEN);

  logic                      in_accept;
  logic                      trigger;
  logic signed [SUM_W-1:0]   sum_x;
  logic signed [SUM_W-1:0]   sum_y;

  logic [DB_W-1:0]           deadband_r, deadband_nxt;
  logic [OFFS_W-1:0]         offs_x_r, offs_x_nxt;
  logic [OFFS_W-1:0]         offs_y_r, offs_y_nxt;
  logic signed [ANGLE_W-1:0] prev_x_r, prev_x_nxt;
  logic signed [ANGLE_W-1:0] prev_y_r, prev_y_nxt;
  logic                      pend_r, pend_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  logic [OFFS_W-1:0]         offs_x_eff;
  logic [OFFS_W-1:0]         offs_y_eff;
  logic                      pend_eff;
  logic [OFFS_W-1:0]         mean_x;
  logic [OFFS_W-1:0]         mean_y;
  logic signed [ANGLE_W-1:0] rel_x;
  logic signed [ANGLE_W-1:0] rel_y;
  logic [MAG_W-1:0]          mag_x;
  logic [MAG_W-1:0]          mag_y;
  logic                      neg_x;
  logic                      neg_y;

  // A sample item needs no result slot; a trigger needs the result register free.
  assign in_ready  = !trigger || !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  tazd_accum #(
    .AVG_LEN (AVG_LEN)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .angle_x (in_data.angle_x),
    .angle_y (in_data.angle_y),
    .trigger (trigger),
    .sum_x   (sum_x),
    .sum_y   (sum_y)
  );

  // Clear takes effect before the result of the same item is formed.
  assign offs_x_eff = in_data.clear_offset ? '0 : offs_x_r;
  assign offs_y_eff = in_data.clear_offset ? '0 : offs_y_r;
  assign pend_eff   = pend_r || in_data.zero_req;

  tazd_axis #(
    .AVG_LEN (AVG_LEN)
  ) u_axis_x (
    .sum      (sum_x),
    .offset   (offs_x_eff),
    .prev     (prev_x_r),
    .deadband (deadband_r),
    .mean_abs (mean_x),
    .rel_held (rel_x),
    .mag      (mag_x),
    .neg      (neg_x)
  );

  tazd_axis #(
    .AVG_LEN (AVG_LEN)
  ) u_axis_y (
    .sum      (sum_y),
    .offset   (offs_y_eff),
    .prev     (prev_y_r),
    .deadband (deadband_r),
    .mean_abs (mean_y),
    .rel_held (rel_y),
    .mag      (mag_y),
    .neg      (neg_y)
  );

  // State update for each accepted item and the result register.
  always_comb begin
    deadband_nxt  = deadband_r;
    offs_x_nxt    = offs_x_r;
    offs_y_nxt    = offs_y_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (cfg_valid) begin
      deadband_nxt = cfg_data;
    end

    if (in_accept) begin
      offs_x_nxt = offs_x_eff;
      offs_y_nxt = offs_y_eff;
      pend_nxt   = pend_eff;
      if (trigger) begin
        prev_x_nxt                = rel_x;
        prev_y_nxt                = rel_y;
        out_valid_nxt             = 1'b1;
        out_data_nxt.tilt_x_mag   = mag_x;
        out_data_nxt.tilt_x_neg   = neg_x;
        out_data_nxt.tilt_y_mag   = mag_y;
        out_data_nxt.tilt_y_neg   = neg_y;
        out_data_nxt.tilt_x_value = rel_x;
        if (pend_eff) begin
          offs_x_nxt = mean_x;
          offs_y_nxt = mean_y;
          pend_nxt   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r  <= DB_RESET;
      offs_x_r    <= '0;
      offs_y_r    <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      deadband_r  <= deadband_nxt;
      offs_x_r    <= offs_x_nxt;
      offs_y_r    <= offs_y_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* sim/tilt_average_zero_deadband_top_tb.sv */
// Self-checking testbench for tilt_average_zero_deadband_top.
// Holds a tracker class that predicts each averaged tilt result and checks the block.
// Depends on tazd_pkg and the tilt_average_zero_deadband_top RTL.
`timescale 1ns / 1ps

module tilt_average_zero_deadband_top_tb;
  import tazd_pkg::*;

  localparam int AVG_LEN       = AVG_LEN_DEF;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLDOFF_LEN   = 150;
  localparam int SETTLE_CYCLES = 4;
  localparam int BLOCKS_PER_PHASE = 7;

  // Predicts the averaged, offset and deadband-held tilt for every trigger item.
  class tilt_mean_tracker;
    int unsigned deadband;
    int          sum_x;
    int          sum_y;
    int unsigned sample_count;
    int unsigned zero_offs_x;
    int unsigned zero_offs_y;
    int          held_x;
    int          held_y;
    bit          zero_pending;
    out_item_t   expected_tilts[$];
    int unsigned errors;
    int unsigned items_seen;
    int unsigned results_seen;
    int unsigned holds_seen;
    int unsigned captures_seen;

    function new();
      deadband      = DB_RESET;
      sum_x         = 0;
      sum_y         = 0;
      sample_count  = 0;
      zero_offs_x   = 0;
      zero_offs_y   = 0;
      held_x        = 0;
      held_y        = 0;
      zero_pending  = 1'b0;
      errors        = 0;
      items_seen    = 0;
      results_seen  = 0;
      holds_seen    = 0;
      captures_seen = 0;
    endfunction

    function int pending();
      return expected_tilts.size();
    endfunction

    // One axis: rounded mean magnitude, relative value, arrow and deadband hold.
    function void axis_tilt(input int sum, input int unsigned offset, inout int held,
                            output int unsigned mean_mag, output int rel, output bit neg);
      int unsigned mag;
      int unsigned q;
      bit          mean_neg;
      int          diff;
      mag      = (sum < 0) ? -sum : sum;
      q        = (mag + AVG_LEN / 2) / AVG_LEN;
      mean_neg = (sum < 0) && (q != 0);
      if (q > OFFS_MAX) q = OFFS_MAX;
      rel = int'(q) - int'(offset);
      neg = (offset != 0) ? (rel < 0) : mean_neg;
      diff = rel - held;
      if (diff < 0) diff = -diff;
      if (diff < deadband) begin
        rel = held;
        holds_seen++;
      end
      held     = rel;
      mean_mag = q;
    endfunction

    // Fold one accepted item into the state; a trigger queues one expected result.
    function void note_sample(in_item_t item);
      int unsigned mag_x;
      int unsigned mag_y;
      int          rel_x;
      int          rel_y;
      bit          neg_x;
      bit          neg_y;
      int          abs_x;
      int          abs_y;
      out_item_t   want;
      items_seen++;
      if (item.clear_offset) begin
        zero_offs_x = 0;
        zero_offs_y = 0;
      end
      if (item.zero_req) zero_pending = 1'b1;
      if (sample_count < AVG_LEN) begin
        sum_x += $signed(item.angle_x);
        sum_y += $signed(item.angle_y);
        sample_count++;
        return;
      end
      axis_tilt(sum_x, zero_offs_x, held_x, mag_x, rel_x, neg_x);
      axis_tilt(sum_y, zero_offs_y, held_y, mag_y, rel_y, neg_y);
      abs_x = (rel_x < 0) ? -rel_x : rel_x;
      abs_y = (rel_y < 0) ? -rel_y : rel_y;
      want.tilt_x_mag   = abs_x[MAG_W-1:0];
      want.tilt_x_neg   = neg_x;
      want.tilt_y_mag   = abs_y[MAG_W-1:0];
      want.tilt_y_neg   = neg_y;
      want.tilt_x_value = rel_x[ANGLE_W-1:0];
      expected_tilts.push_back(want);
      if (zero_pending) begin
        zero_offs_x  = mag_x;
        zero_offs_y  = mag_y;
        zero_pending = 1'b0;
        captures_seen++;
      end
      sum_x        = 0;
      sum_y        = 0;
      sample_count = 0;
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest expected tilt.
    function void check_tilt_result(out_item_t got);
      out_item_t want;
      if (expected_tilts.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d %0d %0d %0d %0d",
                 $time, got.tilt_x_mag, got.tilt_x_neg, got.tilt_y_mag, got.tilt_y_neg,
                 got.tilt_x_value);
        errors++;
        return;
      end
      want = expected_tilts.pop_front();
      results_seen++;
      compare_field("tilt_x_mag", want.tilt_x_mag, got.tilt_x_mag);
      compare_field("tilt_x_neg", want.tilt_x_neg, got.tilt_x_neg);
      compare_field("tilt_y_mag", want.tilt_y_mag, got.tilt_y_mag);
      compare_field("tilt_y_neg", want.tilt_y_neg, got.tilt_y_neg);
      compare_field("tilt_x_value", $signed(want.tilt_x_value), $signed(got.tilt_x_value));
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  in_item_t        in_data;
  logic            out_valid;
  logic            out_ready;
  out_item_t       out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [DB_W-1:0] cfg_data;

  tilt_mean_tracker tracker;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          holdoff_request;
  int          quiet_cycles;
  int          base_x;
  int          base_y;
  int unsigned settings_written;

  tilt_average_zero_deadband_top #(
    .AVG_LEN(AVG_LEN)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watch every handshake at the rising edge and feed the tracker.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) tracker.check_tilt_result(out_data);
      if (in_valid && in_ready) tracker.note_sample(in_data);
      if (cfg_valid && cfg_ready) tracker.deadband = cfg_data;
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // End the run if nothing moves for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tilt_average_zero_deadband_top: mismatch");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_request) begin
        holdoff_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLDOFF_LEN) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int any_angle();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic in_item_t make_item(int x, int y, bit zero_req, bit clear_offset);
    in_item_t item;
    item.angle_x      = x[ANGLE_W-1:0];
    item.angle_y      = y[ANGLE_W-1:0];
    item.zero_req     = zero_req;
    item.clear_offset = clear_offset;
    return item;
  endfunction

  // Move a block's base angle: mostly near the deadband, sometimes far.
  function automatic int drift(int base, int unsigned db);
    int pick;
    int span;
    int next;
    pick = $urandom_range(99);
    span = int'(db) * 2 + 8;
    if (pick < 70) next = base + int'($urandom_range(0, span)) - span / 2;
    else if (pick < 85) next = base + int'($urandom_range(0, 4000)) - 2000;
    else if (pick < 95) next = int'($urandom_range(0, 36000)) - 18000;
    else next = any_angle();
    return clip16(next);
  endfunction

  // Offer one item; called at a falling edge, returns at a falling edge.
  task automatic send_item(input in_item_t item);
    int gap;
    gap = 0;
    while (gap < 8 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_deadband(input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_data  <= value[DB_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random blocks: a full set of samples around a drifting base, then a trigger.
  task automatic send_blocks(input int n_blocks, input int unsigned db);
    int b;
    int k;
    int x;
    int y;
    for (b = 0; b < n_blocks; b++) begin
      base_x = drift(base_x, db);
      base_y = drift(base_y, db);
      for (k = 0; k <= AVG_LEN; k++) begin
        if (k < AVG_LEN && $urandom_range(99) >= 5) begin
          x = clip16(base_x + int'($urandom_range(0, 6)) - 3);
          y = clip16(base_y + int'($urandom_range(0, 6)) - 3);
        end else begin
          // Noise samples, and the trigger whose angles are ignored.
          x = any_angle();
          y = any_angle();
        end
        send_item(make_item(x, y, $urandom_range(99) < 3, $urandom_range(99) < 3));
      end
    end
  endtask

  // Main sequence: reset, directed blocks, then random phases.
  initial begin
    int unsigned db_setting[6];
    int s;
    int k;
    tracker         = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    holdoff_request = 1'b0;
    quiet_cycles    = 0;
    base_x          = 0;
    base_y          = 0;
    settings_written = 0;
    db_setting[0] = 0;
    db_setting[1] = 1000;
    db_setting[2] = 1023;
    db_setting[3] = $urandom_range(0, 1023);
    db_setting[4] = $urandom_range(0, 60);
    db_setting[5] = $urandom_range(0, 1000);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full-scale block: X at the top, Y saturating; zero request on the trigger.
    for (k = 0; k < AVG_LEN; k++) send_item(make_item(32767, -32768, 1'b0, 1'b0));
    send_item(make_item(-32768, 32767, 1'b1, 1'b0));
    // Clear and zero request together; X rounds a tie away from zero, Y is a negative zero.
    send_item(make_item(-4, -3, 1'b1, 1'b1));
    for (k = 1; k < AVG_LEN; k++) send_item(make_item(0, 0, 1'b0, 1'b0));
    send_item(make_item(12345, -12345, 1'b0, 1'b0));
    // X mean below its offset and inside the deadband: held magnitude, new sign.
    for (k = 0; k < AVG_LEN; k++) send_item(make_item((k % 2) ? 1 : -1, -20, 1'b0, 1'b0));
    send_item(make_item(0, 0, 1'b0, 1'b0));
    wait_drained();

    // Random phases, each with its own deadband and idling pattern.
    for (s = 0; s < 6; s++) begin
      write_deadband(db_setting[s]);
      case (s / 2)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (s == 4) holdoff_request = 1'b1;
      send_blocks(BLOCKS_PER_PHASE, db_setting[s]);
      wait_drained();
    end

    $display("Ran %0d items giving %0d results over %0d deadband settings.",
             tracker.items_seen, tracker.results_seen, settings_written);
    $display("Deadband held %0d axis values; %0d zero offsets were captured.",
             tracker.holds_seen, tracker.captures_seen);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tilt_average_zero_deadband_top: match");
    end else begin
      $display("tilt_average_zero_deadband_top: mismatch");
    end
    $finish;
  end

endmodule
